>>> rtl/magnetometer_compass_heading_assert.svh
// assertion macros for the magnetometer compass heading block
// expects clk and rst in the scope of each use
`ifndef MAGNETOMETER_COMPASS_HEADING_ASSERT_SVH
`define MAGNETOMETER_COMPASS_HEADING_ASSERT_SVH

// same-cycle implication
`define MCH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MCH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/mch_pkg.sv
// shared constants, register codes and the cordic angle table
// for the magnetometer compass heading block; no dependencies
`default_nettype none

package mch_pkg;

  localparam int SAMPLE_BITS_DEF  = 10;
  localparam int CORDIC_STEPS_DEF = 14;
  localparam int ATAN_ENTRIES     = 20;

  localparam int CENTER_BITS     = 10;
  localparam int GAIN_BITS       = 16;
  localparam int OFFSET_BITS     = 14;
  localparam int CFG_INDEX_BITS  = 3;
  localparam int CFG_DATA_BITS   = 16;
  localparam int HEADING_BITS    = 9;
  localparam int OUT_TDATA_BITS  = 16;
  localparam int ATAN_BITS       = 22;
  localparam int ANGLE_BITS      = 25;
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int SCALE_SHIFT     = 10;
  localparam int PRESCALE_SHIFT  = 8;

  // register indexes on the config port
  localparam logic [CFG_INDEX_BITS-1:0] REG_AXIS_CENTER = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_X_GAIN      = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Y_GAIN      = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_X_OFFSET    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_Y_OFFSET    = 3'd4;

  // reset values
  localparam logic [CENTER_BITS-1:0]        AXIS_CENTER_RST = 10'd650;
  localparam logic [GAIN_BITS-1:0]          X_GAIN_RST      = 16'd16384;
  localparam logic [GAIN_BITS-1:0]          Y_GAIN_RST      = 16'd20873;
  localparam logic signed [OFFSET_BITS-1:0] X_OFFSET_RST    = 14'sd544;
  localparam logic signed [OFFSET_BITS-1:0] Y_OFFSET_RST    = -14'sd815;

  // heading constants in whole degrees
  localparam logic [HEADING_BITS-1:0] DEG_0     = 9'd0;
  localparam logic [HEADING_BITS-1:0] DEG_90    = 9'd90;
  localparam logic [HEADING_BITS-1:0] DEG_180   = 9'd180;
  localparam logic [HEADING_BITS-1:0] DEG_270   = 9'd270;
  localparam logic [HEADING_BITS-1:0] DEG_360   = 9'd360;
  localparam logic [7:0]              ANGLE_MAX = 8'd89;

  // sign and zero flags of the calibrated vector
  typedef struct packed {
    logic hx_zero;
    logic hx_neg;
    logic hy_zero;
    logic hy_neg;
  } quad_t;

  // atan(2^-i) in degrees, 16 fractional bits, rounded to nearest
  function automatic logic [ATAN_BITS-1:0] atan_deg_q16(input logic [4:0] idx);
    logic [ATAN_BITS-1:0] r;
    case (idx)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/magnetometer_compass_heading.sv
// magnetometer compass heading: calibration followed by an unrolled cordic pipeline
// depends on mch_pkg and magnetometer_compass_heading_assert.svh
`default_nettype none

// channel   | dir | payload (lowest bits first)              | handshake
// ----------+-----+-------------------------------------------+------------------
// s_axis    | in  | x_sample, y_sample, zero pad to bytes     | s_tvalid/s_tready
// m_axis    | out | heading_degrees, zero pad to 16 bits      | m_tvalid/m_tready
// cfg       | in  | cfg_index selects register, cfg_data      | cfg_wen, no wait
//
// one transaction per cycle while m_tready is high; register stages in order
// (multiply, calibrate, cordic load, one stage per cordic step, heading)
// each stage has its own valid bit; a stage loads when it is empty or the
// next stage loads, so bubbles close up under a stalled output
// rst clears the valid bits and loads the register reset values; no clearing pass

`include "magnetometer_compass_heading_assert.svh"

module magnetometer_compass_heading #(
  parameter int SAMPLE_BITS  = mch_pkg::SAMPLE_BITS_DEF,
  parameter int CORDIC_STEPS = mch_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // x_sample [SAMPLE_BITS-1:0], y_sample [2*SAMPLE_BITS-1:SAMPLE_BITS], zero pad
  input  wire  [((2*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
  input  wire                                   s_tvalid,
  output logic                                  s_tready,
  // heading_degrees [8:0], zero pad
  output logic [mch_pkg::OUT_TDATA_BITS-1:0]    m_tdata,
  output logic                                  m_tvalid,
  input  wire                                   m_tready,
  input  wire                                   cfg_wen,
  input  wire  [mch_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire  [mch_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  // cordic steps actually run, limited by the angle table
  localparam int NSTEP = (CORDIC_STEPS > mch_pkg::ATAN_ENTRIES) ?
                         mch_pkg::ATAN_ENTRIES : CORDIC_STEPS;
  localparam int NSTAGE = NSTEP + 4;

  // centered sample, product, calibrated value, cordic datapath widths
  localparam int DW = ((SAMPLE_BITS > mch_pkg::CENTER_BITS) ?
                       SAMPLE_BITS : mch_pkg::CENTER_BITS) + 1;
  localparam int PW = DW + mch_pkg::GAIN_BITS + 1;
  localparam int HW = PW - mch_pkg::SCALE_SHIFT + 1;
  // two guard bits: sign and cordic gain growth
  localparam int CW = HW + mch_pkg::PRESCALE_SHIFT + 2;
  localparam int ZW = mch_pkg::ANGLE_BITS;
  localparam int FB = mch_pkg::ANGLE_FRAC_BITS;

  // configuration registers
  logic [mch_pkg::CENTER_BITS-1:0]        axis_center;
  logic [mch_pkg::GAIN_BITS-1:0]          x_gain;
  logic [mch_pkg::GAIN_BITS-1:0]          y_gain;
  logic signed [mch_pkg::OFFSET_BITS-1:0] x_offset;
  logic signed [mch_pkg::OFFSET_BITS-1:0] y_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_center <= mch_pkg::AXIS_CENTER_RST;
      x_gain      <= mch_pkg::X_GAIN_RST;
      y_gain      <= mch_pkg::Y_GAIN_RST;
      x_offset    <= mch_pkg::X_OFFSET_RST;
      y_offset    <= mch_pkg::Y_OFFSET_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        mch_pkg::REG_AXIS_CENTER: axis_center <= cfg_data[mch_pkg::CENTER_BITS-1:0];
        mch_pkg::REG_X_GAIN:      x_gain      <= cfg_data[mch_pkg::GAIN_BITS-1:0];
        mch_pkg::REG_Y_GAIN:      y_gain      <= cfg_data[mch_pkg::GAIN_BITS-1:0];
        mch_pkg::REG_X_OFFSET:    x_offset    <= signed'(cfg_data[mch_pkg::OFFSET_BITS-1:0]);
        mch_pkg::REG_Y_OFFSET:    y_offset    <= signed'(cfg_data[mch_pkg::OFFSET_BITS-1:0]);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // valid bits and the ready chain, stage NSTAGE-1 is the output register
  logic [NSTAGE-1:0] v;
  logic [NSTAGE:0]   rdy;
  logic [NSTAGE-1:0] v_in;

  assign rdy[NSTAGE] = m_tready;
  genvar k;
  generate
    for (k = 0; k < NSTAGE; k++) begin : g_rdy
      assign rdy[k] = ~v[k] | rdy[k+1];
    end
  endgenerate

  assign v_in     = {v[NSTAGE-2:0], s_tvalid};
  assign s_tready = rdy[0];
  assign m_tvalid = v[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int j = 0; j < NSTAGE; j++) begin
        if (rdy[j]) v[j] <= v_in[j];
      end
    end
  end

  // stage 0: center and multiply by gain (Q2.14)
  logic [SAMPLE_BITS-1:0] x_sample;
  logic [SAMPLE_BITS-1:0] y_sample;
  logic signed [DW-1:0]   dx;
  logic signed [DW-1:0]   dy;
  logic signed [PW-1:0]   prod_x;
  logic signed [PW-1:0]   prod_y;

  assign x_sample = s_tdata[SAMPLE_BITS-1:0];
  assign y_sample = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign dx = signed'(DW'(x_sample)) - signed'(DW'(axis_center));
  assign dy = signed'(DW'(y_sample)) - signed'(DW'(axis_center));

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      prod_x <= PW'(dx) * signed'(PW'(x_gain));
      prod_y <= PW'(dy) * signed'(PW'(y_gain));
    end
  end

  // stage 1: round half up to 4 fractional bits and add offset
  logic signed [PW-1:0]                     rnd_x;
  logic signed [PW-1:0]                     rnd_y;
  logic signed [PW-mch_pkg::SCALE_SHIFT-1:0] sc_x;
  logic signed [PW-mch_pkg::SCALE_SHIFT-1:0] sc_y;
  logic signed [HW-1:0]                     hx;
  logic signed [HW-1:0]                     hy;

  assign rnd_x = prod_x + PW'(512);
  assign rnd_y = prod_y + PW'(512);
  assign sc_x  = signed'(rnd_x[PW-1:mch_pkg::SCALE_SHIFT]);
  assign sc_y  = signed'(rnd_y[PW-1:mch_pkg::SCALE_SHIFT]);

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      hx <= HW'(sc_x) + HW'(x_offset);
      hy <= HW'(sc_y) + HW'(y_offset);
    end
  end

  // stage 2: magnitudes and quadrant flags, load the cordic
  logic signed [CW-1:0] cx [0:NSTEP];
  logic signed [CW-1:0] cy [0:NSTEP];
  logic signed [ZW-1:0] cz [0:NSTEP];
  mch_pkg::quad_t       cf [0:NSTEP];
  logic [HW-1:0]        ax;
  logic [HW-1:0]        ay;

  assign ax = hx[HW-1] ? HW'(-hx) : HW'(hx);
  assign ay = hy[HW-1] ? HW'(-hy) : HW'(hy);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      cx[0]         <= signed'({2'b00, ax, 8'h00});
      cy[0]         <= signed'({2'b00, ay, 8'h00});
      cz[0]         <= '0;
      cf[0].hx_zero <= (hx == '0);
      cf[0].hx_neg  <= hx[HW-1];
      cf[0].hy_zero <= (hy == '0);
      cf[0].hy_neg  <= hy[HW-1];
    end
  end

  // cordic vectoring steps, one register stage each
  genvar i;
  generate
    for (i = 0; i < NSTEP; i++) begin : g_cordic
      localparam logic signed [ZW-1:0] STEP_ANGLE =
        signed'(ZW'(mch_pkg::atan_deg_q16(5'(i))));
      always_ff @(posedge clk) begin
        if (rdy[3+i]) begin
          if (!cy[i][CW-1]) begin
            cx[i+1] <= cx[i] + (cy[i] >>> i);
            cy[i+1] <= cy[i] - (cx[i] >>> i);
            cz[i+1] <= cz[i] + STEP_ANGLE;
          end else begin
            cx[i+1] <= cx[i] - (cy[i] >>> i);
            cy[i+1] <= cy[i] + (cx[i] >>> i);
            cz[i+1] <= cz[i] - STEP_ANGLE;
          end
          cf[i+1] <= cf[i];
        end
      end
    end
  endgenerate

  // last stage: whole degrees, clamp, place in quadrant
  logic [ZW-FB-2:0]                  a_raw;
  logic [7:0]                        a_lim;
  logic [mch_pkg::HEADING_BITS-1:0]  a_deg;
  logic [mch_pkg::HEADING_BITS-1:0]  heading_next;
  logic [mch_pkg::HEADING_BITS-1:0]  heading;
  mch_pkg::quad_t                    fq;

  assign fq    = cf[NSTEP];
  assign a_raw = cz[NSTEP][ZW-2:FB];
  assign a_lim = (8'(a_raw) > mch_pkg::ANGLE_MAX) ? mch_pkg::ANGLE_MAX : 8'(a_raw);

  always_comb begin
    // zero y skips the angle, negative accumulator floors at zero
    if (fq.hy_zero || cz[NSTEP][ZW-1]) a_deg = mch_pkg::DEG_0;
    else                               a_deg = mch_pkg::HEADING_BITS'(a_lim);

    if (fq.hx_zero) begin
      heading_next = fq.hy_neg ? mch_pkg::DEG_90 : mch_pkg::DEG_270;
    end else if (!fq.hx_neg) begin
      if (fq.hy_neg)                  heading_next = a_deg;
      else if (a_deg == mch_pkg::DEG_0) heading_next = mch_pkg::DEG_0;  // 360 wraps
      else                            heading_next = mch_pkg::DEG_360 - a_deg;
    end else begin
      if (fq.hy_neg)       heading_next = mch_pkg::DEG_180 - a_deg;
      else if (fq.hy_zero) heading_next = mch_pkg::DEG_180;
      else                 heading_next = mch_pkg::DEG_180 + a_deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NSTAGE-1]) heading <= heading_next;
  end

  assign m_tdata = mch_pkg::OUT_TDATA_BITS'(heading);

  // checks
  `MCH_ASSERT_NOW(a_heading_range, m_tvalid, heading < mch_pkg::DEG_360, "heading above 359")
  `MCH_ASSERT_NOW(a_ready_when_free, !v[0], s_tready, "input refused with empty first stage")
  `MCH_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v[0], "accepted transaction lost")
  `MCH_ASSERT_NEXT(a_stage_holds, v[2] && !rdy[3], v[2] && $stable(cx[0]), "stalled stage moved")

endmodule

`default_nettype wire

>>> bench/magnetometer_compass_heading_tb.sv
// self-checking bench for the magnetometer compass heading block: a directed table
// and randomized calibration phases, checked against an in-bench heading predictor
// depends on mch_pkg and the magnetometer_compass_heading rtl
`timescale 1ns / 100ps

module magnetometer_compass_heading_tb;

  // sample width and the byte-padded input payload width
  localparam int SAMPLE_W      = mch_pkg::SAMPLE_BITS_DEF;
  localparam int IN_TDATA_BITS = ((2 * SAMPLE_W + 7) / 8) * 8;
  // cordic rounds actually run: the angle table holds 20 entries
  localparam int CORDIC_ROUNDS = (mch_pkg::CORDIC_STEPS_DEF < mch_pkg::ATAN_ENTRIES) ?
                                 mch_pkg::CORDIC_STEPS_DEF : mch_pkg::ATAN_ENTRIES;
  // pipeline depth as the rtl counts its stages, used for the closing wait
  localparam int PIPE_LATENCY  = CORDIC_ROUNDS + 4;
  // cycles with no transaction on either side before the run is declared hung
  localparam int HANG_LIMIT    = 2000;
  localparam int PHASE_ITEMS   = 133;

  // atan(2^-i) in degrees with 16 fractional bits, rounded to nearest
  localparam longint ATAN_Q16 [mch_pkg::ATAN_ENTRIES] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7
  };

  // calibration register set as the block holds it
  typedef struct packed {
    logic [mch_pkg::CENTER_BITS-1:0]        center;
    logic [mch_pkg::GAIN_BITS-1:0]          xg;
    logic [mch_pkg::GAIN_BITS-1:0]          yg;
    logic signed [mch_pkg::OFFSET_BITS-1:0] xo;
    logic signed [mch_pkg::OFFSET_BITS-1:0] yo;
  } cal_t;

  // one line of the directed table; known marks a heading typed in by hand
  typedef struct packed {
    cal_t                             cal;
    logic [SAMPLE_W-1:0]              xs;
    logic [SAMPLE_W-1:0]              ys;
    logic                             known;
    logic [mch_pkg::HEADING_BITS-1:0] heading;
  } dir_row_t;

  // calibration flavors for the random phases
  typedef enum int {CAL_RESET, CAL_UNITY, CAL_RANDOM, CAL_TOP, CAL_BOTTOM} cal_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // x_sample [9:0], y_sample [19:10], zero pad
  logic [IN_TDATA_BITS-1:0]           s_tdata  = '0;
  logic                               s_tvalid = 1'b0;
  wire                                s_tready;
  // heading_degrees [8:0], zero pad
  wire  [mch_pkg::OUT_TDATA_BITS-1:0] m_tdata;
  wire                                m_tvalid;
  logic                               m_tready = 1'b0;
  logic                               cfg_wen   = 1'b0;
  logic [mch_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [mch_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

  // calibration the block holds right now, as the bench last wrote it
  cal_t cal_now = '{center: mch_pkg::AXIS_CENTER_RST, xg: mch_pkg::X_GAIN_RST,
                    yg: mch_pkg::Y_GAIN_RST, xo: mch_pkg::X_OFFSET_RST,
                    yo: mch_pkg::Y_OFFSET_RST};

  logic [mch_pkg::HEADING_BITS-1:0] heading_q [$];
  dir_row_t                         dir_rows [$];
  int                               errors     = 0;
  int                               burst_left = 0;
  int                               idle_count = 0;
  int                               rx_left    = 0;
  int                               rx_mode    = 0;

  magnetometer_compass_heading u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tdata   (m_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // heading predictor
  // ---------------------------------------------------------------------------

  // (raw - center) * gain in Q2.14, rounded half up to 4 fractional bits, plus offset
  function automatic longint calibrated(input logic [SAMPLE_W-1:0] raw,
                                        input logic [mch_pkg::CENTER_BITS-1:0] center,
                                        input logic [mch_pkg::GAIN_BITS-1:0] gain,
                                        input logic signed [mch_pkg::OFFSET_BITS-1:0] off);
    longint d;
    d = longint'(raw) - longint'(center);
    return ((d * longint'(gain) + 512) >>> mch_pkg::SCALE_SHIFT) + longint'(off);
  endfunction

  // floor of atan(ay / ax) in whole degrees for ax > 0, ay >= 0, held to 0..89
  function automatic int first_quad_deg(input longint ax, input longint ay);
    longint x, y, z, xs, ys;
    int     i;
    if (ay == 0)
      return 0;  // zero y component skips the rotation entirely
    x = ax <<< mch_pkg::PRESCALE_SHIFT;
    y = ay <<< mch_pkg::PRESCALE_SHIFT;
    z = 0;
    for (i = 0; i < CORDIC_ROUNDS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + ATAN_Q16[i];
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - ATAN_Q16[i];
      end
    end
    if (z < 0)
      z = 0;
    z = z >>> mch_pkg::ANGLE_FRAC_BITS;
    if (z > 89)
      z = 89;
    return int'(z);
  endfunction

  function automatic logic [mch_pkg::HEADING_BITS-1:0] predict_heading(
      input cal_t c, input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys);
    longint hx, hy;
    int     a, hd;
    hx = calibrated(xs, c.center, c.xg, c.xo);
    hy = calibrated(ys, c.center, c.yg, c.yo);
    if (hx == 0) begin
      hd = (hy < 0) ? 90 : 270;
    end else begin
      a = first_quad_deg((hx < 0) ? -hx : hx, (hy < 0) ? -hy : hy);
      if (hx > 0)
        hd = (hy < 0) ? a : ((a == 0) ? 0 : 360 - a);  // due north folds to 0
      else if (hy > 0)
        hd = 180 + a;
      else if (hy < 0)
        hd = 180 - a;
      else
        hd = 180;
    end
    return hd[mch_pkg::HEADING_BITS-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic cal_t make_cal(input int center, input int xg, input int yg,
                                    input int xo, input int yo);
    cal_t c;
    c.center = center[mch_pkg::CENTER_BITS-1:0];
    c.xg     = xg[mch_pkg::GAIN_BITS-1:0];
    c.yg     = yg[mch_pkg::GAIN_BITS-1:0];
    c.xo     = xo[mch_pkg::OFFSET_BITS-1:0];
    c.yo     = yo[mch_pkg::OFFSET_BITS-1:0];
    return c;
  endfunction

  // min, max or uniform per register, weighted toward the extremes
  function automatic int pick_reg(input int lo, input int hi);
    int r;
    r = $urandom_range(0, 3);
    if (r == 0)
      return lo;
    if (r == 1)
      return hi;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic cal_t pick_cal(input cal_kind_t kind);
    cal_t c;
    case (kind)
      CAL_RESET: begin
        c = make_cal(int'(mch_pkg::AXIS_CENTER_RST), int'(mch_pkg::X_GAIN_RST),
                     int'(mch_pkg::Y_GAIN_RST), int'(mch_pkg::X_OFFSET_RST),
                     int'(mch_pkg::Y_OFFSET_RST));
      end
      // unity gain and offsets on a 1.0 grid, so some samples land exactly on zero
      CAL_UNITY: begin
        c = make_cal($urandom_range(200, 800), 16384, 16384,
                     16 * (int'($urandom_range(0, 1022)) - 511),
                     16 * (int'($urandom_range(0, 1022)) - 511));
      end
      CAL_TOP: begin
        c = make_cal(1023, 65535, 65535, 8191, 8191);
      end
      CAL_BOTTOM: begin
        c = make_cal(0, 0, 0, -8192, -8192);
      end
      default: begin
        c = make_cal(pick_reg(0, 1023), pick_reg(0, 65535), pick_reg(0, 65535),
                     pick_reg(-8192, 8191), pick_reg(-8192, 8191));
      end
    endcase
    return c;
  endfunction

  // extremes, the sample that zeroes the axis under unity gain or a neighbour, or uniform
  function automatic logic [SAMPLE_W-1:0] pick_sample(
      input logic [mch_pkg::CENTER_BITS-1:0] center,
      input logic signed [mch_pkg::OFFSET_BITS-1:0] off);
    int r, zp;
    r  = $urandom_range(0, 7);
    zp = int'(center) - int'(off) / 16 + int'($urandom_range(0, 2)) - 1;
    if (zp < 0)
      zp = 0;
    if (zp > 1023)
      zp = 1023;
    case (r)
      0:       return '0;
      1:       return '1;
      2, 3:    return zp[SAMPLE_W-1:0];
      default: return SAMPLE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  task automatic add_row(input cal_t c, input int xs, input int ys,
                         input logic known, input int hd);
    dir_row_t row;
    row.cal     = c;
    row.xs      = xs[SAMPLE_W-1:0];
    row.ys      = ys[SAMPLE_W-1:0];
    row.known   = known;
    row.heading = hd[mch_pkg::HEADING_BITS-1:0];
    dir_rows.push_back(row);
  endtask

  // one transaction on the config port; no wait state, so it lands at this edge
  task automatic write_reg(input logic [mch_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [mch_pkg::CFG_DATA_BITS-1:0] data);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // registers change only with nothing in flight; junk above center and offsets checks masking
  task automatic apply_cal(input cal_t c);
    logic [mch_pkg::CFG_DATA_BITS-1:0] junk;
    if (c != cal_now) begin
      s_tvalid <= 1'b0;
      while (heading_q.size() != 0)
        @(posedge clk);
      junk = mch_pkg::CFG_DATA_BITS'($urandom);
      write_reg(mch_pkg::REG_AXIS_CENTER,
                {junk[mch_pkg::CFG_DATA_BITS-1:mch_pkg::CENTER_BITS], c.center});
      write_reg(mch_pkg::REG_X_GAIN, c.xg);
      write_reg(mch_pkg::REG_Y_GAIN, c.yg);
      junk = mch_pkg::CFG_DATA_BITS'($urandom);
      write_reg(mch_pkg::REG_X_OFFSET,
                {junk[mch_pkg::CFG_DATA_BITS-1:mch_pkg::OFFSET_BITS], c.xo});
      junk = mch_pkg::CFG_DATA_BITS'($urandom);
      write_reg(mch_pkg::REG_Y_OFFSET,
                {junk[mch_pkg::CFG_DATA_BITS-1:mch_pkg::OFFSET_BITS], c.yo});
      // an index past the register list must leave everything alone
      write_reg(mch_pkg::CFG_INDEX_BITS'($urandom_range(2 ** mch_pkg::CFG_INDEX_BITS - 1,
                                                        mch_pkg::REG_Y_OFFSET + 1)),
                mch_pkg::CFG_DATA_BITS'($urandom));
      cfg_wen <= 1'b0;
      cal_now = c;
    end
  endtask

  // offer one sample pair, hold until the transaction, then maybe open a gap
  task automatic send_item(input logic [SAMPLE_W-1:0] xs, input logic [SAMPLE_W-1:0] ys,
                           input logic known, input logic [mch_pkg::HEADING_BITS-1:0] hd);
    int gap;
    s_tdata  <= {{(IN_TDATA_BITS - 2 * SAMPLE_W){1'b0}}, ys, xs};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready)
      @(posedge clk);
    heading_q.push_back(known ? hd : predict_heading(cal_now, xs, ys));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      // bursts of random length; a quarter of them run straight on with no gap
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic report_mismatch(input string what,
                                 input logic [mch_pkg::HEADING_BITS-1:0] got,
                                 input logic [mch_pkg::HEADING_BITS-1:0] want);
    errors++;
    $display("heading check failed (%s) at %0t: got %0d, want %0d", what, $realtime,
             got, want);
  endtask

  // ---------------------------------------------------------------------------
  // receiver: stall pattern and result check
  // ---------------------------------------------------------------------------

  // modes: always ready, mostly ready, coin flip, full stall; each held for a run
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(1, 60);
    end else begin
      rx_left--;
    end
    case (rx_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= ($urandom_range(0, 3) != 0);
      2:       m_tready <= ($urandom_range(0, 1) != 0);
      default: m_tready <= 1'b0;
    endcase
  end

  // every output transaction pairs with the oldest predicted heading
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (heading_q.size() == 0)
        report_mismatch("no heading expected", m_tdata[mch_pkg::HEADING_BITS-1:0], '0);
      else if (m_tdata[mch_pkg::HEADING_BITS-1:0] != heading_q[0])
        report_mismatch("heading_degrees", m_tdata[mch_pkg::HEADING_BITS-1:0],
                        heading_q.pop_front());
      else
        void'(heading_q.pop_front());
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_count = 0;
    else
      idle_count++;
    if (idle_count >= HANG_LIMIT) begin
      $display("magnetometer_compass_heading: mismatch");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    cal_t      rc, c;
    cal_kind_t phases [10];
    int        p, n;

    rc = pick_cal(CAL_RESET);

    // reset calibration, raw extremes and the center point
    add_row(rc, 0, 0, 1'b0, 0);
    add_row(rc, 1023, 1023, 1'b0, 0);
    add_row(rc, 0, 1023, 1'b0, 0);
    add_row(rc, 1023, 0, 1'b0, 0);
    add_row(rc, 650, 650, 1'b0, 0);
    add_row(rc, 511, 512, 1'b0, 0);
    // zero gains: the vector is the offsets alone, which pins every quadrant rule
    add_row(make_cal(0, 0, 0, 0, -16), 1023, 0, 1'b1, 90);      // on the x axis, y south
    add_row(make_cal(0, 0, 0, 0, 0), 0, 1023, 1'b1, 270);       // zero vector
    add_row(make_cal(0, 0, 0, 0, 8191), 512, 512, 1'b1, 270);   // on the x axis, y north
    add_row(make_cal(0, 0, 0, 8191, 0), 0, 0, 1'b1, 0);         // zero y, 360 folds to 0
    add_row(make_cal(0, 0, 0, -8192, 0), 1023, 1023, 1'b1, 180); // zero y, x negative
    add_row(make_cal(0, 0, 0, 8191, 1), 7, 9, 1'b1, 0);
    add_row(make_cal(0, 0, 0, -8192, -1), 9, 7, 1'b1, 180);
    add_row(make_cal(0, 0, 0, 16, 16), 0, 0, 1'b0, 0);
    add_row(make_cal(0, 0, 0, 16, -16), 0, 0, 1'b0, 0);
    add_row(make_cal(0, 0, 0, -16, 16), 0, 0, 1'b0, 0);
    add_row(make_cal(0, 0, 0, -16, -16), 0, 0, 1'b0, 0);
    add_row(make_cal(0, 0, 0, 1, -8192), 0, 0, 1'b0, 0);        // steep angle near clamp
    add_row(make_cal(0, 0, 0, -1, 8191), 0, 0, 1'b0, 0);
    // full-scale registers
    add_row(make_cal(0, 65535, 65535, 8191, 8191), 1023, 1023, 1'b0, 0);
    add_row(make_cal(0, 65535, 65535, 8191, 8191), 0, 0, 1'b0, 0);
    add_row(make_cal(1023, 65535, 65535, -8192, -8192), 0, 0, 1'b0, 0);
    add_row(make_cal(1023, 65535, 65535, -8192, -8192), 1023, 1023, 1'b0, 0);
    // unity gain, x lands exactly on zero while y points south
    add_row(make_cal(512, 16384, 16384, 0, 0), 512, 0, 1'b1, 90);

    phases = '{CAL_RESET, CAL_UNITY, CAL_RANDOM, CAL_TOP, CAL_UNITY,
               CAL_RANDOM, CAL_BOTTOM, CAL_RANDOM, CAL_UNITY, CAL_RANDOM};

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      apply_cal(dir_rows[i].cal);
      send_item(dir_rows[i].xs, dir_rows[i].ys, dir_rows[i].known, dir_rows[i].heading);
    end

    for (p = 0; p < $size(phases); p++) begin
      c = pick_cal(phases[p]);
      apply_cal(c);
      for (n = 0; n < PHASE_ITEMS; n++)
        send_item(pick_sample(c.center, c.xo), pick_sample(c.center, c.yo), 1'b0, '0);
    end

    // drain, then give any stray result time to show up
    s_tvalid <= 1'b0;
    while (heading_q.size() != 0)
      @(posedge clk);
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    if (errors == 0)
      $display("magnetometer_compass_heading: match");
    else
      $display("magnetometer_compass_heading: mismatch");
    $finish;
  end

endmodule
